[hw/rtl/swk_pkg.sv]
// ----------------------------------------------------------------------------
// swk_pkg: shared constants, types and tables
// Widths, limits and the arctangent table used by the swerve kinematics block.
// ----------------------------------------------------------------------------
package swk_pkg;

    localparam int WHEEL_COUNT_DEF   = 4;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int WHEEL_MAX         = 4;

    localparam int FIELD_W    = 16;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_COUNT  = 8;
    localparam int PROD_W     = 32;
    localparam int SX_W       = 25;
    localparam int SQ_W       = 49;
    localparam int CW         = 48;
    localparam int ZW         = 32;
    localparam int PRESCALE_SH = 20;
    localparam int ISQRT_STEPS = 24;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [FIELD_W-1:0] RATE_LIMIT = 16'sd24576;
    localparam logic [SQ_W-1:0]           VALID_SQ   = 49'd10737418;
    localparam logic signed [ZW-1:0]      DEG90      = 32'sd5760;
    localparam logic signed [ZW-1:0]      DEG_MIN    = -32'sd5760;
    localparam logic signed [ZW-1:0]      DEG_MAX    = 32'sd17280;
    localparam logic signed [ZW-1:0]      DEG180_FINE = 32'sd754974720;
    localparam logic [FIELD_W-1:0]        SPEED_MAX  = 16'hFFFF;

    // one wheel in flight through the main pipe
    typedef struct packed {
        logic                   vld;
        logic [IDX_W-1:0]       widx;
        logic                   zero;
        logic                   sv;
        logic [SQ_W-1:0]        n;
        logic [SQ_W-1:0]        r;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [ZW-1:0]   z;
    } step_t;

    // atan(2^-i) in units of 2^-16 / 64 degree
    function automatic logic signed [ZW-1:0] atan_fine(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 32'sd188743680;
            5'd1:  v = 32'sd111421900;
            5'd2:  v = 32'sd58872272;
            5'd3:  v = 32'sd29884485;
            5'd4:  v = 32'sd15000234;
            5'd5:  v = 32'sd7507429;
            5'd6:  v = 32'sd3754631;
            5'd7:  v = 32'sd1877430;
            5'd8:  v = 32'sd938729;
            5'd9:  v = 32'sd469366;
            5'd10: v = 32'sd234683;
            5'd11: v = 32'sd117342;
            5'd12: v = 32'sd58671;
            5'd13: v = 32'sd29335;
            5'd14: v = 32'sd14668;
            5'd15: v = 32'sd7334;
            5'd16: v = 32'sd3667;
            5'd17: v = 32'sd1833;
            5'd18: v = 32'sd917;
            5'd19: v = 32'sd458;
            5'd20: v = 32'sd229;
            5'd21: v = 32'sd115;
            5'd22: v = 32'sd57;
            5'd23: v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/swk_if.sv]
// ----------------------------------------------------------------------------
// swk_if: channel interfaces
// Command, wheel result and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
interface swk_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [15:0] yaw_rate;

    modport source (output valid, velocity_x, velocity_y, yaw_rate, input ready);
    modport sink   (input valid, velocity_x, velocity_y, yaw_rate, output ready);
endinterface

interface swk_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         wheel_index;
    logic [15:0]        wheel_speed;
    logic signed [15:0] steer_angle;
    logic               steer_valid;
    logic               last_wheel;

    modport source (output valid, wheel_index, wheel_speed, steer_angle, steer_valid,
                    last_wheel, input ready);
    modport sink   (input valid, wheel_index, wheel_speed, steer_angle, steer_valid,
                    last_wheel, output ready);
endinterface

interface swk_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/swerve_wheel_kinematics.sv]
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics: swerve drive inverse kinematics
// Turns one chassis command into a speed and steering angle per wheel.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one transaction per chassis command (velocity_x, velocity_y in
//         Q8.8 m/s, yaw_rate in Q4.12 rad/s, saturated to +-6).
//   res : WHEEL_COUNT transactions per command, wheel 0 first; last_wheel
//         marks the final one. steer_angle is 90 deg minus atan2, 1/64 deg.
//   cfg : wheel offsets (Q2.14 m), index 0..7 = x0,y0,x1,y1,...; higher
//         indexes are dropped. ready is always high. Write only while idle.
// Throughput: one wheel result per cycle while res does not stall; the
//   command register issues one wheel per advancing cycle and takes the
//   next command as it issues the last wheel of the current one.
// Pipeline: issue, multiply, rotate-add, square/CORDIC prep, sum, 24
//   square-root steps that also carry the CORDIC stages, output register.
// Stall: the whole pipe holds while res is valid and not ready; no
//   transaction is lost or repeated. Reset clears the pipe valid bits,
//   the issue state and the offsets (to zero).
// ----------------------------------------------------------------------------
module swerve_wheel_kinematics #(
    parameter int WHEEL_COUNT   = swk_pkg::WHEEL_COUNT_DEF,
    parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    swk_cmd_if.sink       cmd,
    swk_res_if.source     res,
    swk_cfg_if.sink       cfg
);
    import swk_pkg::*;

    localparam int CORDIC_N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WHEEL_COUNT - 1);

    typedef struct packed {
        logic                      vld;
        logic [IDX_W-1:0]          widx;
        logic signed [FIELD_W-1:0] vx;
        logic signed [FIELD_W-1:0] vy;
        logic signed [PROD_W-1:0]  px;
        logic signed [PROD_W-1:0]  py;
    } mul_t;

    typedef struct packed {
        logic                      vld;
        logic [IDX_W-1:0]          widx;
        logic signed [SX_W-1:0]    sx;
        logic signed [SX_W-1:0]    sy;
    } vec_t;

    typedef struct packed {
        logic                      vld;
        logic [IDX_W-1:0]          widx;
        logic                      zero;
        logic [SQ_W-1:0]           sqx;
        logic [SQ_W-1:0]           sqy;
        logic signed [CW-1:0]      x;
        logic signed [CW-1:0]      y;
        logic signed [ZW-1:0]      z;
    } prep_t;

    typedef struct packed {
        logic                      vld;
        logic [IDX_W-1:0]          widx;
        logic [FIELD_W-1:0]        speed;
        logic signed [FIELD_W-1:0] steer;
        logic                      sv;
        logic                      last;
    } out_t;

    // offsets, one entry per wheel
    logic signed [FIELD_W-1:0] xoff_reg [WHEEL_MAX];
    logic signed [FIELD_W-1:0] yoff_reg [WHEEL_MAX];

    // command register and wheel issue counter
    logic                      busy_reg;
    logic [IDX_W-1:0]          widx_reg;
    logic signed [FIELD_W-1:0] vx_reg, vy_reg, rate_reg;
    logic signed [FIELD_W-1:0] rate_clamped;

    logic  adv;
    mul_t  s1_reg, s1_next;
    vec_t  s2_reg, s2_next;
    prep_t s3_reg, s3_next;
    step_t s4_reg, s4_next;
    step_t stg_in   [ISQRT_STEPS];
    step_t stg_next [ISQRT_STEPS];
    step_t stg_reg  [ISQRT_STEPS];
    out_t  out_reg, out_next;

    // whole pipe moves unless a result is waiting on a stalled receiver
    assign adv       = !out_reg.vld || res.ready;
    assign cmd.ready = adv && (!busy_reg || widx_reg == LAST_IDX);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (cmd.yaw_rate > RATE_LIMIT)
            rate_clamped = RATE_LIMIT;
        else if (cmd.yaw_rate < -RATE_LIMIT)
            rate_clamped = -RATE_LIMIT;
        else
            rate_clamped = cmd.yaw_rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WHEEL_MAX; i++)
            begin
                xoff_reg[i] <= '0;
                yoff_reg[i] <= '0;
            end
        end
        else if (cfg.valid && cfg.index < CFG_IDX_W'(CFG_COUNT))
        begin
            if (cfg.index[0])
                yoff_reg[cfg.index[2:1]] <= cfg.data;
            else
                xoff_reg[cfg.index[2:1]] <= cfg.data;
        end
    end

    // issue: one wheel per advancing cycle while a command is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            widx_reg <= '0;
        end
        else if (cmd.valid && cmd.ready)
        begin
            busy_reg <= 1'b1;
            widx_reg <= '0;
        end
        else if (adv && busy_reg)
        begin
            if (widx_reg == LAST_IDX)
                busy_reg <= 1'b0;
            widx_reg <= widx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            vx_reg   <= cmd.velocity_x;
            vy_reg   <= cmd.velocity_y;
            rate_reg <= rate_clamped;
        end
    end

    // stage 1: rotation products
    always_comb
    begin
        s1_next.vld  = busy_reg;
        s1_next.widx = widx_reg;
        s1_next.vx   = vx_reg;
        s1_next.vy   = vy_reg;
        s1_next.px   = yoff_reg[widx_reg] * rate_reg;
        s1_next.py   = xoff_reg[widx_reg] * rate_reg;
    end

    // stage 2: round products to Q8.16, add translation
    always_comb
    begin
        logic signed [PROD_W+1:0] rx;
        logic signed [PROD_W+1:0] ry;
        rx = ($signed({{2{s1_reg.px[PROD_W-1]}}, s1_reg.px}) + 34'sd512) >>> 10;
        ry = (-$signed({{2{s1_reg.py[PROD_W-1]}}, s1_reg.py}) + 34'sd512) >>> 10;
        s2_next.vld  = s1_reg.vld;
        s2_next.widx = s1_reg.widx;
        s2_next.sx   = $signed({s1_reg.vx[FIELD_W-1], s1_reg.vx, 8'd0}) + SX_W'(rx);
        s2_next.sy   = $signed({s1_reg.vy[FIELD_W-1], s1_reg.vy, 8'd0}) + SX_W'(ry);
    end

    // stage 3: squares, CORDIC start (turn left half-plane by 180 deg)
    always_comb
    begin
        logic signed [2*SX_W-1:0] qx;
        logic signed [2*SX_W-1:0] qy;
        logic signed [CW-1:0]     xp;
        logic signed [CW-1:0]     yp;
        qx = s2_reg.sx * s2_reg.sx;
        qy = s2_reg.sy * s2_reg.sy;
        xp = CW'($signed({s2_reg.sx, PRESCALE_SH'(0)}));
        yp = CW'($signed({s2_reg.sy, PRESCALE_SH'(0)}));
        s3_next.vld  = s2_reg.vld;
        s3_next.widx = s2_reg.widx;
        s3_next.zero = (s2_reg.sx == '0) && (s2_reg.sy == '0);
        s3_next.sqx  = SQ_W'(qx);
        s3_next.sqy  = SQ_W'(qy);
        if (s2_reg.sx < 0)
        begin
            s3_next.x = -xp;
            s3_next.y = -yp;
            s3_next.z = (s2_reg.sy >= 0) ? DEG180_FINE : -DEG180_FINE;
        end
        else
        begin
            s3_next.x = xp;
            s3_next.y = yp;
            s3_next.z = '0;
        end
    end

    // stage 4: sum of squares
    always_comb
    begin
        s4_next.vld  = s3_reg.vld;
        s4_next.widx = s3_reg.widx;
        s4_next.zero = s3_reg.zero;
        s4_next.sv   = 1'b0;
        s4_next.n    = s3_reg.sqx + s3_reg.sqy;
        s4_next.r    = '0;
        s4_next.x    = s3_reg.x;
        s4_next.y    = s3_reg.y;
        s4_next.z    = s3_reg.z;
    end

    // steps: a square-root digit per stage, a CORDIC rotation below CORDIC_N
    assign stg_in[0] = s4_reg;
    for (genvar k = 0; k < ISQRT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQRT_STEPS - 1 - k));
        if (k > 0)
        begin : g_link
            assign stg_in[k] = stg_reg[k-1];
        end

        always_comb
        begin
            logic [SQ_W-1:0] trial;
            trial       = stg_in[k].r + BIT;
            stg_next[k] = stg_in[k];
            if (k == 0)
                stg_next[k].sv = stg_in[k].n > VALID_SQ;
            if (stg_in[k].n >= trial)
            begin
                stg_next[k].n = stg_in[k].n - trial;
                stg_next[k].r = (stg_in[k].r >> 1) + BIT;
            end
            else
            begin
                stg_next[k].r = stg_in[k].r >> 1;
            end
            if (k < CORDIC_N)
            begin
                if (stg_in[k].y > 0)
                begin
                    stg_next[k].x = stg_in[k].x + (stg_in[k].y >>> k);
                    stg_next[k].y = stg_in[k].y - (stg_in[k].x >>> k);
                    stg_next[k].z = stg_in[k].z + atan_fine(5'(k));
                end
                else
                begin
                    stg_next[k].x = stg_in[k].x - (stg_in[k].y >>> k);
                    stg_next[k].y = stg_in[k].y + (stg_in[k].x >>> k);
                    stg_next[k].z = stg_in[k].z - atan_fine(5'(k));
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stg_reg[k] <= '0;
            else if (adv)
                stg_reg[k] <= stg_next[k];
        end
    end

    // output: round speed and angle, saturate, clamp
    always_comb
    begin
        logic [SQ_W-1:0]      sp;
        logic signed [ZW-1:0] zr;
        logic signed [ZW-1:0] st;
        sp = (stg_reg[ISQRT_STEPS-1].r + SQ_W'(128)) >> 8;
        zr = (stg_reg[ISQRT_STEPS-1].z + 32'sd32768) >>> 16;
        st = stg_reg[ISQRT_STEPS-1].zero ? DEG90 : DEG90 - zr;
        if (st < DEG_MIN)
            st = DEG_MIN;
        else if (st > DEG_MAX)
            st = DEG_MAX;
        out_next.vld   = stg_reg[ISQRT_STEPS-1].vld;
        out_next.widx  = stg_reg[ISQRT_STEPS-1].widx;
        out_next.speed = (sp > SQ_W'(SPEED_MAX)) ? SPEED_MAX : FIELD_W'(sp);
        out_next.steer = FIELD_W'(st);
        out_next.sv    = stg_reg[ISQRT_STEPS-1].sv;
        out_next.last  = stg_reg[ISQRT_STEPS-1].widx == LAST_IDX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            s4_reg  <= '0;
            out_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            out_reg <= out_next;
        end
    end

    assign res.valid       = out_reg.vld;
    assign res.wheel_index = out_reg.widx;
    assign res.wheel_speed = out_reg.speed;
    assign res.steer_angle = out_reg.steer;
    assign res.steer_valid = out_reg.sv;
    assign res.last_wheel  = out_reg.last;

endmodule

[hw/rtl/swk_checker.sv]
// ----------------------------------------------------------------------------
// swk_checker: port-level checks
// Watches the result channel of the swerve kinematics block.
// ----------------------------------------------------------------------------
module swk_checker #(
    parameter int WHEEL_COUNT = swk_pkg::WHEEL_COUNT_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_wheel_index,
    input logic [15:0] res_wheel_speed,
    input logic [15:0] res_steer_angle,
    input logic        res_steer_valid,
    input logic        res_last_wheel
);
    import swk_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WHEEL_COUNT - 1);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_wheel_index)
            && $stable(res_wheel_speed) && $stable(res_steer_angle))
        else $error("result changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_last_wheel == (res_wheel_index == LAST_IDX)))
        else $error("last flag does not match wheel index");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last_wheel |=> !res_valid
            || res_wheel_index == $past(res_wheel_index) + 2'd1)
        else $error("wheel order broken");

    a_slow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_wheel_speed == '0 |-> !res_steer_valid)
        else $error("steer valid at zero speed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $signed(res_steer_angle) >= -16'sd5760
            && $signed(res_steer_angle) <= 16'sd17280)
        else $error("steer angle out of range");

endmodule

bind swerve_wheel_kinematics swk_checker #(.WHEEL_COUNT(WHEEL_COUNT)) u_swk_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_wheel_index (res.wheel_index),
    .res_wheel_speed (res.wheel_speed),
    .res_steer_angle (res.steer_angle),
    .res_steer_valid (res.steer_valid),
    .res_last_wheel  (res.last_wheel)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: swerve wheel kinematics check
// Random and directed chassis commands with bursty input and stalled output;
// each wheel result is compared with a cycle-free predictor of the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import swk_pkg::*;

    // register indexes, in the block's order
    typedef enum logic [3:0] {
        REG_X0 = 4'd0, REG_Y0 = 4'd1, REG_X1 = 4'd2, REG_Y1 = 4'd3,
        REG_X2 = 4'd4, REG_Y2 = 4'd5, REG_X3 = 4'd6, REG_Y3 = 4'd7,
        REG_NONE = 4'd8
    } wheel_reg_e;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] rate;
    } chassis_cmd_t;

    typedef struct packed {
        logic [1:0]         widx;
        logic [15:0]        speed;
        logic signed [15:0] angle;
        logic               sv;
        logic               last;
    } wheel_out_t;

    logic clk;
    logic rst_n;

    swk_cmd_if cmd ();
    swk_res_if res ();
    swk_cfg_if cfg ();

    swerve_wheel_kinematics dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    // predictor copy of the offset registers (x then y per wheel)
    logic signed [15:0] wheel_geom [4][2];

    chassis_cmd_t pending_cmds [$];
    wheel_out_t   wheel_expect [$];
    int           errors;
    int           received;
    bit           sender_on;    // gates the driver during register phases
    bit           cmd_accepted; // command transaction taken at the last rising edge
    int           burst_left;
    int           gap_left;
    int           stall_mode;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---- predictor -------------------------------------------------------
    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC, 1/64 deg scaled by 2^16
    function automatic longint heading_fine(longint sx, longint sy);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = sx * 1048576;
        y = sy * 1048576;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 754974720 : -754974720;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_ENTRIES; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_fine(5'(i)));
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_fine(5'(i)));
            end
        end
        return z;
    endfunction

    task automatic predict_wheels(input chassis_cmd_t c);
        longint vx;
        longint vy;
        longint rate;
        longint sx;
        longint sy;
        longint sq;
        longint spd;
        longint ang;
        wheel_out_t o;
        vx = longint'(c.vx) * 256;
        vy = longint'(c.vy) * 256;
        rate = longint'(c.rate);
        if (rate > 24576)
            rate = 24576;
        else if (rate < -24576)
            rate = -24576;
        for (int w = 0; w < WHEEL_COUNT_DEF; w++)
        begin
            sx = vx + round_sh(longint'(wheel_geom[w][1]) * rate, 10);
            sy = vy + round_sh(-(longint'(wheel_geom[w][0]) * rate), 10);
            sq = sx * sx + sy * sy;
            spd = (int_sqrt(sq) + 128) >> 8;
            if (spd > 65535)
                spd = 65535;
            if (sx == 0 && sy == 0)
                ang = 5760;
            else
                ang = 5760 - round_sh(heading_fine(sx, sy), 16);
            if (ang < -5760)
                ang = -5760;
            else if (ang > 17280)
                ang = 17280;
            o.widx = 2'(w);
            o.speed = 16'(spd);
            o.angle = 16'(ang);
            o.sv = (sq > 10737418);
            o.last = (w == WHEEL_COUNT_DEF - 1);
            wheel_expect.push_back(o);
        end
    endtask

    // ---- command driver: bursts with random gaps -------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (cmd.valid && !cmd_accepted)
                cmd.valid <= 1'b1;    // hold the waiting transaction
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                cmd.valid <= 1'b0;
            end
            else if (sender_on && pending_cmds.size() > 0)
            begin
                cmd.valid <= 1'b1;
                {cmd.velocity_x, cmd.velocity_y, cmd.yaw_rate} <= pending_cmds[0];
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // ---- result ready pattern, mode changes now and then -----------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: res.ready <= 1'b1;
                1: res.ready <= ($urandom_range(0, 3) != 0);
                2: res.ready <= ($urandom_range(0, 3) == 0);
                default: res.ready <= ~res.ready;
            endcase
        end
    end

    // ---- monitor: sample at rising edge, predict and compare -------------
    always @(posedge clk)
    begin
        wheel_out_t want;
        cmd_accepted = rst_n && cmd.valid && cmd.ready;
        if (cmd_accepted)
        begin
            predict_wheels({cmd.velocity_x, cmd.velocity_y, cmd.yaw_rate});
            void'(pending_cmds.pop_front());
        end
        if (rst_n && res.valid && res.ready)
        begin
            received <= received + 1;
            if (wheel_expect.size() == 0)
            begin
                $error("unexpected wheel transaction index %0d", res.wheel_index);
                errors++;
            end
            else
            begin
                want = wheel_expect.pop_front();
                if (res.wheel_index !== want.widx)
                begin
                    $error("wheel_index exp %0d got %0d", want.widx, res.wheel_index);
                    errors++;
                end
                if (res.wheel_speed !== want.speed)
                begin
                    $error("wheel_speed exp %0d got %0d", want.speed, res.wheel_speed);
                    errors++;
                end
                if (res.steer_angle !== want.angle)
                begin
                    $error("steer_angle exp %0d got %0d", want.angle, res.steer_angle);
                    errors++;
                end
                if (res.steer_valid !== want.sv)
                begin
                    $error("steer_valid exp %0d got %0d", want.sv, res.steer_valid);
                    errors++;
                end
                if (res.last_wheel !== want.last)
                begin
                    $error("last_wheel exp %0d got %0d", want.last, res.last_wheel);
                    errors++;
                end
            end
        end
    end

    // ---- register writes, only while the pipe is empty -------------------
    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx < 4'(CFG_COUNT))
            wheel_geom[idx >> 1][idx[0]] = val;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic load_geometry(input int style);
        logic [15:0] v;
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            case (style)
                0: v = 16'h0000;
                1: v = (i[0] ^ i[1]) ? 16'h8000 : 16'h7FFF;       // extremes
                2: v = 16'($signed($urandom_range(0, 16384)) - 8192); // realistic
                default: v = 16'($urandom);
            endcase
            write_reg(4'(i), v);
        end
    endtask

    // run a phase of commands and wait for every wheel result to drain
    task automatic run_phase();
        sender_on = 1'b1;
        while (pending_cmds.size() > 0 || cmd.valid)
            @(posedge clk);
        sender_on = 1'b0;
        while (wheel_expect.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic chassis_cmd_t rand_cmd();
        chassis_cmd_t c;
        c = chassis_cmd_t'(48'({$urandom, $urandom}));
        // mostly modest speeds and in-range rates; some full-scale noise
        if ($urandom_range(0, 3) != 0)
        begin
            c.vx = 16'($signed($urandom_range(0, 2048)) - 1024);
            c.vy = 16'($signed($urandom_range(0, 2048)) - 1024);
            c.rate = 16'($signed($urandom_range(0, 49152)) - 24576);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            c.vx = 16'($signed($urandom_range(0, 26)) - 13);
            c.vy = 16'($signed($urandom_range(0, 26)) - 13);
            c.rate = '0;
        end
        return c;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        received = 0;
        sender_on = 1'b0;
        cmd.valid = 1'b0;
        cmd.velocity_x = '0;
        cmd.velocity_y = '0;
        cmd.yaw_rate = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        for (int i = 0; i < 4; i++)
        begin
            wheel_geom[i][0] = '0;
            wheel_geom[i][1] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero offsets, field extremes, zero vector, threshold edge
        pending_cmds.push_back('{16'sd0, 16'sd0, 16'sd0});
        pending_cmds.push_back('{16'sh7FFF, 16'sh7FFF, 16'sd0});
        pending_cmds.push_back('{-16'sd32768, -16'sd32768, 16'sd0});
        pending_cmds.push_back('{-16'sd32768, 16'sd0, 16'sd0});
        pending_cmds.push_back('{-16'sd5, 16'sd0, 16'sd0});
        pending_cmds.push_back('{-16'sd5, -16'sd1, 16'sd0});
        pending_cmds.push_back('{16'sd0, 16'sd13, 16'sd0});
        pending_cmds.push_back('{16'sd0, 16'sd12, 16'sd0});
        pending_cmds.push_back('{16'sd0, -16'sd256, 16'sd0});
        run_phase();

        // extreme offsets with rates beyond and at the clamp
        load_geometry(1);
        write_reg(REG_NONE, 16'h1234);
        write_reg(4'hF, 16'hFFFF);
        pending_cmds.push_back('{16'sd0, 16'sd0, 16'sh7FFF});
        pending_cmds.push_back('{16'sd0, 16'sd0, -16'sd32768});
        pending_cmds.push_back('{16'sd0, 16'sd0, 16'sd24576});
        pending_cmds.push_back('{16'sd0, 16'sd0, -16'sd24576});
        pending_cmds.push_back('{16'sd0, 16'sd0, 16'sd24577});
        pending_cmds.push_back('{16'sh7FFF, -16'sd32768, 16'sd1});
        pending_cmds.push_back('{-16'sd32768, 16'sh7FFF, -16'sd1});
        run_phase();

        // random phases over several geometries, zero last
        for (int p = 0; p < 6; p++)
        begin
            load_geometry(p == 5 ? 0 : (p == 0 ? 1 : (p % 2 ? 2 : 3)));
            for (int k = 0; k < 52; k++)
                pending_cmds.push_back(rand_cmd());
            run_phase();
        end

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("testbench: FAIL");
        $finish;
    end
endmodule
